FILE: hdl/dla_pkg.sv
// Package for the debounced limit alarm: register indexes, config and result types.
// No dependencies; imported by dla_core and debounced_limit_alarm.
`default_nettype none

package dla_pkg;

   localparam int unsigned SampleWidth = 16;
   localparam int unsigned RunWidth    = 16;
   localparam int unsigned CsrWidth    = 16;

   localparam logic [RunWidth-1:0] RunMax = {RunWidth{1'b1}};

   typedef enum logic [1:0] {
      CSR_HIGH_LIMIT      = 2'd0,
      CSR_LOW_LIMIT       = 2'd1,
      CSR_DEBOUNCE_COUNT  = 2'd2,
      CSR_HIGH_AUTO_CLEAR = 2'd3
   } dla_csr_index_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] high_limit;
      logic signed [SampleWidth-1:0] low_limit;
      logic [RunWidth-1:0]           debounce_count;
      logic                          high_auto_clear;
   } dla_cfg_type;

   typedef struct packed {
      logic high_active;
      logic low_active;
      logic fault_active;
      logic fault_raised;
      logic fault_cleared;
      logic high_raised;
      logic high_cleared;
      logic low_raised;
      logic low_cleared;
   } dla_result_type;

   // saturating run counter increment
   function automatic logic [RunWidth-1:0] run_inc(input logic [RunWidth-1:0] r);
      logic [RunWidth-1:0] nxt;
      nxt = (r == RunMax) ? RunMax : r + {{(RunWidth-1){1'b0}}, 1'b1};
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/dla_core.sv
// Alarm state (flags and run counters) and its per-request update logic.
// Depends on dla_pkg.
`default_nettype none

module dla_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dla_pkg::dla_cfg_type                  cfg,
   input  wire logic                                  update_en,
   input  wire logic signed [dla_pkg::SampleWidth-1:0] sample_value,
   input  wire logic                                  sample_ok,
   input  wire logic                                  sensor_failed,
   output dla_pkg::dla_result_type                    result
);
   import dla_pkg::*;

   logic                high_flag_ff, high_flag_in;
   logic                low_flag_ff, low_flag_in;
   logic                fault_flag_ff, fault_flag_in;
   logic [RunWidth-1:0] above_run_ff, above_run_in;
   logic [RunWidth-1:0] below_run_ff, below_run_in;
   logic [RunWidth-1:0] high_clr_run_ff, high_clr_run_in;
   logic [RunWidth-1:0] low_clr_run_ff, low_clr_run_in;
   logic                is_above;
   logic                is_below;

   assign is_above = sample_value > cfg.high_limit;
   assign is_below = sample_value < cfg.low_limit;

   always_comb begin
      high_flag_in    = high_flag_ff;
      low_flag_in     = low_flag_ff;
      fault_flag_in   = fault_flag_ff;
      above_run_in    = above_run_ff;
      below_run_in    = below_run_ff;
      high_clr_run_in = high_clr_run_ff;
      low_clr_run_in  = low_clr_run_ff;
      result          = '0;

      if (sensor_failed) begin
         // fault wipes the runs, flags hold
         above_run_in    = '0;
         below_run_in    = '0;
         high_clr_run_in = '0;
         low_clr_run_in  = '0;
         if (!fault_flag_ff) begin
            fault_flag_in       = 1'b1;
            result.fault_raised = 1'b1;
         end
      end else begin
         if (fault_flag_ff) begin
            fault_flag_in        = 1'b0;
            result.fault_cleared = 1'b1;
         end
         if (sample_ok) begin
            priority if (is_above) begin
               above_run_in    = run_inc(above_run_ff);
               below_run_in    = '0;
               high_clr_run_in = '0;
               low_clr_run_in  = '0;
               if (!high_flag_ff && above_run_in >= cfg.debounce_count) begin
                  high_flag_in       = 1'b1;
                  result.high_raised = 1'b1;
               end
            end else if (is_below) begin
               below_run_in    = run_inc(below_run_ff);
               above_run_in    = '0;
               high_clr_run_in = '0;
               low_clr_run_in  = '0;
               if (!low_flag_ff && below_run_in >= cfg.debounce_count) begin
                  low_flag_in       = 1'b1;
                  result.low_raised = 1'b1;
               end
            end else begin
               above_run_in = '0;
               below_run_in = '0;
               if (cfg.high_auto_clear && high_flag_ff) begin
                  high_clr_run_in = run_inc(high_clr_run_ff);
                  if (high_clr_run_in >= cfg.debounce_count) begin
                     high_flag_in        = 1'b0;
                     result.high_cleared = 1'b1;
                  end
               end
               if (low_flag_ff) begin
                  low_clr_run_in = run_inc(low_clr_run_ff);
                  if (low_clr_run_in >= cfg.debounce_count) begin
                     low_flag_in        = 1'b0;
                     result.low_cleared = 1'b1;
                  end
               end
            end
         end
      end

      result.high_active  = high_flag_in;
      result.low_active   = low_flag_in;
      result.fault_active = fault_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_flag_ff    <= 1'b0;
         low_flag_ff     <= 1'b0;
         fault_flag_ff   <= 1'b0;
         above_run_ff    <= '0;
         below_run_ff    <= '0;
         high_clr_run_ff <= '0;
         low_clr_run_ff  <= '0;
      end else if (update_en) begin
         high_flag_ff    <= high_flag_in;
         low_flag_ff     <= low_flag_in;
         fault_flag_ff   <= fault_flag_in;
         above_run_ff    <= above_run_in;
         below_run_ff    <= below_run_in;
         high_clr_run_ff <= high_clr_run_in;
         low_clr_run_ff  <= low_clr_run_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/debounced_limit_alarm.sv
// Top level of the debounced limit alarm: request register, config registers,
// result register. Depends on dla_pkg and dla_core.
// Requests pass the request register, then the result register that drives rsp_valid.
// Throughput: one request per cycle while rsp_stall is low; the request and result
//   registers form a two-entry pipe, so a request is taken while a result waits.
// Reset: synchronous, active high; clears alarm flags, run counters and pipe valids
//   and loads the config registers with their defaults.
`default_nettype none

module debounced_limit_alarm (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // config write port
   input  wire logic                                  csr_write_en,
   input  wire logic [1:0]                            csr_index,
   input  wire logic [dla_pkg::CsrWidth-1:0]          csr_wdata,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [dla_pkg::SampleWidth-1:0] req_sample_value,
   input  wire logic                                  req_sample_ok,
   input  wire logic                                  req_sensor_failed,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_high_active,
   output logic                                       rsp_low_active,
   output logic                                       rsp_fault_active,
   output logic                                       rsp_fault_raised,
   output logic                                       rsp_fault_cleared,
   output logic                                       rsp_high_raised,
   output logic                                       rsp_high_cleared,
   output logic                                       rsp_low_raised,
   output logic                                       rsp_low_cleared
);
   import dla_pkg::*;

   // config registers
   dla_cfg_type cfg_ff;

   // request register stage
   logic                          req_vld_ff;
   logic signed [SampleWidth-1:0] sample_ff;
   logic                          ok_ff;
   logic                          failed_ff;

   // result register stage
   logic           rsp_vld_ff;
   dla_result_type rsp_ff;
   dla_result_type core_result;

   logic advance;    // result register can take a new entry
   logic req_take;   // request accepted this cycle
   logic move;       // request register moves into the result register

   dla_csr_index_type csr_sel;
   assign csr_sel = dla_csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_limit      <= 16'sh7FFF;
         cfg_ff.low_limit       <= 16'sh8000;
         cfg_ff.debounce_count  <= 16'd3;
         cfg_ff.high_auto_clear <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_sel)
            CSR_HIGH_LIMIT:      cfg_ff.high_limit      <= $signed(csr_wdata);
            CSR_LOW_LIMIT:       cfg_ff.low_limit       <= $signed(csr_wdata);
            CSR_DEBOUNCE_COUNT:  cfg_ff.debounce_count  <= csr_wdata;
            CSR_HIGH_AUTO_CLEAR: cfg_ff.high_auto_clear <= csr_wdata[0];
            default:             ;
         endcase
      end
   end

   // pipe control: each stage advances when the one behind it is free
   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign move      = req_vld_ff && advance;
   assign req_stall = req_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_take) begin
         req_vld_ff <= 1'b1;
      end else if (move) begin
         req_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_sample_value;
         ok_ff     <= req_sample_ok;
         failed_ff <= req_sensor_failed;
      end
   end

   // alarm state is committed exactly when the request moves to the result stage
   dla_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .update_en     (move),
      .sample_value  (sample_ff),
      .sample_ok     (ok_ff),
      .sensor_failed (failed_ff),
      .result        (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= move;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_high_active   = rsp_ff.high_active;
   assign rsp_low_active    = rsp_ff.low_active;
   assign rsp_fault_active  = rsp_ff.fault_active;
   assign rsp_fault_raised  = rsp_ff.fault_raised;
   assign rsp_fault_cleared = rsp_ff.fault_cleared;
   assign rsp_high_raised   = rsp_ff.high_raised;
   assign rsp_high_cleared  = rsp_ff.high_cleared;
   assign rsp_low_raised    = rsp_ff.low_raised;
   assign rsp_low_cleared   = rsp_ff.low_cleared;

   // the high raise pulse and the low clear pulse agree with their flags
   a_high_raise: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.high_raised) |-> (rsp_ff.high_active && !rsp_ff.high_cleared))
      else $error("high raise pulse without high alarm");

   a_low_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.low_cleared) |-> !rsp_ff.low_active)
      else $error("low clear pulse with low alarm still set");

   // a fault request never touches the limit alarms
   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.fault_raised) |->
         !(rsp_ff.high_raised || rsp_ff.low_raised ||
           rsp_ff.high_cleared || rsp_ff.low_cleared))
      else $error("limit event on a fault request");

   // a held result with a full request register must back-pressure the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_stall && req_vld_ff) |-> req_stall)
      else $error("request taken while pipe is full");

   // a result is only loaded from a pending request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_vld_ff)) |-> $past(req_vld_ff))
      else $error("result appeared without a request");

endmodule

`default_nettype wire

FILE: sim/dla_checker.sv
// Checker for debounced_limit_alarm: watches the config, request and result channels,
// predicts each result from its own alarm model and compares field by field.
// Depends on dla_pkg for the register indexes and the config and result types.
`timescale 1ns / 100ps

module dla_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_en,
   input  wire logic [1:0]                             csr_index,
   input  wire logic [dla_pkg::CsrWidth-1:0]           csr_wdata,
   input  wire logic                                   req_valid,
   input  wire logic                                   req_stall,
   input  wire logic signed [dla_pkg::SampleWidth-1:0] req_sample_value,
   input  wire logic                                   req_sample_ok,
   input  wire logic                                   req_sensor_failed,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   input  wire logic                                   rsp_high_active,
   input  wire logic                                   rsp_low_active,
   input  wire logic                                   rsp_fault_active,
   input  wire logic                                   rsp_fault_raised,
   input  wire logic                                   rsp_fault_cleared,
   input  wire logic                                   rsp_high_raised,
   input  wire logic                                   rsp_high_cleared,
   input  wire logic                                   rsp_low_raised,
   input  wire logic                                   rsp_low_cleared,
   output int                                          mismatch_count,
   output int                                          pending_count
);
   import dla_pkg::*;

   dla_cfg_type         cfg;
   logic                high_flag, low_flag, fault_flag;
   logic [RunWidth-1:0] above_run, below_run, high_clear_run, low_clear_run;
   dla_result_type      expected_alarms[$];
   int                  errors = 0;
   int                  rsp_seen = 0;

   function automatic logic [RunWidth-1:0] bump_run(input logic [RunWidth-1:0] r);
      return (r == {RunWidth{1'b1}}) ? r : r + 1'b1;
   endfunction

   function automatic string field_name(input int bit_pos);
      case (bit_pos)
         8: return "high_active";
         7: return "low_active";
         6: return "fault_active";
         5: return "fault_raised";
         4: return "fault_cleared";
         3: return "high_raised";
         2: return "high_cleared";
         1: return "low_raised";
         default: return "low_cleared";
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns  MISMATCH  %s", $time, what);
      errors++;
   endtask

   // one sample through the alarm logic; updates flags and run counters
   function automatic dla_result_type predict_alarms(input logic signed [SampleWidth-1:0] sample,
                                                     input logic ok, input logic failed);
      dla_result_type res;
      res = '0;
      if (failed) begin
         above_run      = '0;
         below_run      = '0;
         high_clear_run = '0;
         low_clear_run  = '0;
         if (!fault_flag) begin
            fault_flag       = 1'b1;
            res.fault_raised = 1'b1;
         end
      end else begin
         if (fault_flag) begin
            fault_flag        = 1'b0;
            res.fault_cleared = 1'b1;
         end
         if (ok) begin
            if (sample > $signed(cfg.high_limit)) begin
               above_run      = bump_run(above_run);
               below_run      = '0;
               high_clear_run = '0;
               low_clear_run  = '0;
               if (!high_flag && above_run >= cfg.debounce_count) begin
                  high_flag       = 1'b1;
                  res.high_raised = 1'b1;
               end
            end else if (sample < $signed(cfg.low_limit)) begin
               below_run      = bump_run(below_run);
               above_run      = '0;
               high_clear_run = '0;
               low_clear_run  = '0;
               if (!low_flag && below_run >= cfg.debounce_count) begin
                  low_flag       = 1'b1;
                  res.low_raised = 1'b1;
               end
            end else begin
               above_run = '0;
               below_run = '0;
               if (cfg.high_auto_clear && high_flag) begin
                  high_clear_run = bump_run(high_clear_run);
                  if (high_clear_run >= cfg.debounce_count) begin
                     high_flag        = 1'b0;
                     res.high_cleared = 1'b1;
                  end
               end
               if (low_flag) begin
                  low_clear_run = bump_run(low_clear_run);
                  if (low_clear_run >= cfg.debounce_count) begin
                     low_flag        = 1'b0;
                     res.low_cleared = 1'b1;
                  end
               end
            end
         end
      end
      res.high_active  = high_flag;
      res.low_active   = low_flag;
      res.fault_active = fault_flag;
      return res;
   endfunction

   always @(posedge clock) begin
      dla_result_type got, want;
      if (reset) begin
         cfg.high_limit      = 16'sh7FFF;
         cfg.low_limit       = 16'sh8000;
         cfg.debounce_count  = 16'd3;
         cfg.high_auto_clear = 1'b1;
         high_flag      = 1'b0;
         low_flag       = 1'b0;
         fault_flag     = 1'b0;
         above_run      = '0;
         below_run      = '0;
         high_clear_run = '0;
         low_clear_run  = '0;
         expected_alarms.delete();
      end else begin
         if (csr_write_en) begin
            case (dla_csr_index_type'(csr_index))
               CSR_HIGH_LIMIT:      cfg.high_limit      = csr_wdata;
               CSR_LOW_LIMIT:       cfg.low_limit       = csr_wdata;
               CSR_DEBOUNCE_COUNT:  cfg.debounce_count  = csr_wdata;
               CSR_HIGH_AUTO_CLEAR: cfg.high_auto_clear = csr_wdata[0];
               default: ;
            endcase
         end
         // results come from older requests, so compare before queuing this edge's request
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_high_active, rsp_low_active, rsp_fault_active,
                   rsp_fault_raised, rsp_fault_cleared, rsp_high_raised,
                   rsp_high_cleared, rsp_low_raised, rsp_low_cleared};
            if (expected_alarms.size() == 0) begin
               report_mismatch($sformatf("result %0d with no request outstanding", rsp_seen));
            end else begin
               want = expected_alarms.pop_front();
               for (int i = $bits(dla_result_type) - 1; i >= 0; i--) begin
                  if (got[i] !== want[i])
                     report_mismatch($sformatf("result %0d %s: got %b, expected %b",
                                               rsp_seen, field_name(i), got[i], want[i]));
               end
            end
            rsp_seen++;
         end
         if (req_valid && !req_stall)
            expected_alarms.push_back(predict_alarms(req_sample_value, req_sample_ok,
                                                     req_sensor_failed));
      end
      pending_count  <= expected_alarms.size();
      mismatch_count <= errors;
   end

endmodule

FILE: sim/debounced_limit_alarm_test.sv
// Testbench top for debounced_limit_alarm: clock, reset, config writes, sample requests
// and result back-pressure, plus the verdict. Depends on dla_pkg, the RTL and dla_checker.
`timescale 1ns / 100ps

module debounced_limit_alarm_test;
   import dla_pkg::*;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_write_en;
   logic [1:0]                    csr_index;
   logic [CsrWidth-1:0]           csr_wdata;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SampleWidth-1:0] req_sample_value;
   logic                          req_sample_ok;
   logic                          req_sensor_failed;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_high_active, rsp_low_active, rsp_fault_active;
   logic                          rsp_fault_raised, rsp_fault_cleared;
   logic                          rsp_high_raised, rsp_high_cleared;
   logic                          rsp_low_raised, rsp_low_cleared;
   int                            mismatch_count;
   int                            pending_count;

   // idle rates in percent: sender gaps between requests, receiver stall
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   // copy of the current limits, used only to steer the sample generator
   int lim_high = 32767;
   int lim_low  = -32768;
   int deb      = 3;

   debounced_limit_alarm dut (.*);

   dla_checker u_checker (.*);

   always #1 clock = ~clock;

   // result back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_stall <= (int'($urandom_range(99)) < rx_stall_pct);

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // one request: optional random gap first, then hold until accepted.
   // Returns at the accepting edge with req_valid still high.
   task automatic send_sample(input logic signed [SampleWidth-1:0] value,
                              input logic ok, input logic failed);
      while (int'($urandom_range(99)) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_value  <= value;
      req_sample_ok     <= ok;
      req_sensor_failed <= failed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait for every outstanding result, plus pipe latency slack
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // writes all four registers back to back; block is idle by then
   task automatic write_config(input logic [15:0] high_val, input logic [15:0] low_val,
                               input logic [15:0] deb_val, input logic auto_clr);
      drain_results();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_HIGH_LIMIT;
      csr_wdata    <= high_val;
      @(posedge clock);
      csr_index    <= CSR_LOW_LIMIT;
      csr_wdata    <= low_val;
      @(posedge clock);
      csr_index    <= CSR_DEBOUNCE_COUNT;
      csr_wdata    <= deb_val;
      @(posedge clock);
      // upper bits are junk: only bit 0 of this register counts
      csr_index    <= CSR_HIGH_AUTO_CLEAR;
      csr_wdata    <= {15'($urandom), auto_clr};
      @(posedge clock);
      csr_write_en <= 1'b0;
      lim_high = int'($signed(high_val));
      lim_low  = int'($signed(low_val));
      deb      = int'(deb_val);
   endtask

   task automatic pick_config();
      int lo, hi, db;
      case ($urandom_range(9))
         0: begin              // widest window: nothing ever out of range
            hi = 32767;
            lo = -32768;
         end
         1: begin              // inverted extremes: all but -32768 are above, -32768 is below
            hi = -32768;
            lo = 32767;
         end
         2: begin              // anything, inverted windows included
            hi = int'($urandom_range(65535)) - 32768;
            lo = int'($urandom_range(65535)) - 32768;
         end
         default: begin
            lo = int'($urandom_range(3000)) - 2000;
            hi = lo + int'($urandom_range(1500));
         end
      endcase
      case ($urandom_range(9))
         0:       db = 0;
         1:       db = 65535;
         2:       db = 1;
         default: db = int'($urandom_range(6, 2));
      endcase
      write_config(16'(hi), 16'(lo), 16'(db), 1'($urandom));
   endtask

   // value in a zone: 0 above the high limit, 1 below the low limit, 2 in range.
   // Falls back to a random value when the zone is empty.
   function automatic logic signed [SampleWidth-1:0] zone_value(input int zone);
      int v;
      v = int'($signed(16'($urandom)));
      case (zone)
         0: if (lim_high < 32767) begin
               if ($urandom_range(7) == 0) v = 32767;
               else v = lim_high + 1 +
                        int'($urandom_range((32766 - lim_high < 300) ? 32766 - lim_high : 300));
            end
         1: if (lim_low > -32768) begin
               if ($urandom_range(7) == 0) v = -32768;
               else v = lim_low - 1 -
                        int'($urandom_range((lim_low + 32767 < 300) ? lim_low + 32767 : 300));
            end
         default: if (lim_low <= lim_high) begin
               case ($urandom_range(7))
                  0:       v = lim_low;
                  1:       v = lim_high;
                  default: v = lim_low + int'($urandom_range(lim_high - lim_low));
               endcase
            end
      endcase
      return 16'(v);
   endfunction

   // runs of same-zone valid samples, sized around the debounce count so alarms
   // really raise and clear, with faults, invalid samples and wild values mixed in
   task automatic random_burst(input int n);
      int sent, zone, run_len, k, roll;
      sent = 0;
      while (sent < n) begin
         zone    = $urandom_range(2);
         run_len = 1 + int'($urandom_range((deb < 6) ? deb + 2 : 7));
         for (k = 0; k < run_len && sent < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 5)
               send_sample(16'($urandom), 1'($urandom), 1'b1);
            else if (roll < 12)
               send_sample(16'($urandom), 1'b0, 1'b0);
            else if (roll < 15)
               send_sample(16'($urandom), 1'b1, 1'b0);
            else
               send_sample(zone_value(zone), 1'b1, 1'b0);
            sent++;
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_HIGH_LIMIT;
      csr_wdata         <= '0;
      req_valid         <= 1'b0;
      req_sample_value  <= '0;
      req_sample_ok     <= 1'b0;
      req_sensor_failed <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct  = 9;
      rx_stall_pct = 83;

      // ---- directed part ----
      // reset limits: full scale is in range
      send_sample(16'sh7FFF, 1'b1, 1'b0);

      write_config(16'd100, -16'sd100, 16'd2, 1'b1);
      send_sample(16'sh7FFF, 1'b1, 1'b0);   // above, run of one
      send_sample(16'sh7FFF, 1'b1, 1'b0);   // high alarm raises
      send_sample(16'sd0, 1'b1, 1'b0);      // first in-range sample toward clear
      send_sample(16'sd0, 1'b1, 1'b1);      // fault: counters drop, high alarm held
      send_sample(16'sh7FFF, 1'b0, 1'b1);   // fault persists, no new pulse
      send_sample(16'sh1234, 1'b0, 1'b0);   // invalid, no fault: only fault clears
      send_sample(16'sh8000, 1'b1, 1'b0);   // below
      send_sample(16'sh8000, 1'b1, 1'b0);   // low alarm raises
      send_sample(16'sd0, 1'b1, 1'b0);
      send_sample(16'sd0, 1'b1, 1'b0);      // both alarms clear together
      send_sample(16'sd100, 1'b1, 1'b0);    // on the limits is in range
      send_sample(-16'sd100, 1'b1, 1'b0);
      send_sample(16'sd101, 1'b1, 1'b0);
      send_sample(-16'sd101, 1'b1, 1'b0);

      // inverted window, zero debounce, no auto-clear: high test wins
      write_config(-16'sd50, 16'sd50, 16'd0, 1'b0);
      send_sample(16'sd0, 1'b1, 1'b0);      // above since 0 > -50, raises at once
      send_sample(-16'sd60, 1'b1, 1'b0);    // below, raises at once
      send_sample(16'sh7FFF, 1'b1, 1'b1);   // fault with both alarms up

      write_config(16'd0, 16'd0, 16'd0, 1'b0);
      send_sample(16'sd0, 1'b1, 1'b0);      // fault clears, low clears, high stays
      send_sample(16'sd0, 1'b1, 1'b0);

      write_config(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1);
      send_sample(16'sh7FFF, 1'b1, 1'b0);   // at the extremes: still in range
      send_sample(16'sh8000, 1'b1, 1'b0);

      // ---- random part: three idle profiles, several configs each ----
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 9;  rx_stall_pct = 83; end
            1: begin tx_idle_pct = 83; rx_stall_pct = 9;  end
            default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
         endcase
         repeat (8) begin
            pick_config();
            random_burst(48);
         end
      end

      // maximum debounce: a short run above the limit keeps the high alarm down
      write_config(16'd0, -16'sd100, 16'hFFFF, 1'b1);
      repeat (8) send_sample(16'sd1000, 1'b1, 1'b0);
      send_sample(16'sd0, 1'b1, 1'b0);

      drain_results();
      if (mismatch_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: sim.f
hdl/dla_pkg.sv
hdl/dla_core.sv
hdl/debounced_limit_alarm.sv
sim/dla_checker.sv
sim/debounced_limit_alarm_test.sv
